>>> rtl/core/uibl_pkg.sv
// ----------------------------------------------------------------------------
// uibl_pkg: shared types and constants
// Payload structs, request codes and count helpers for the list
// intersection block.
// ----------------------------------------------------------------------------
`default_nettype none

package uibl_pkg;

    localparam int unsigned KEY_W = 32;
    localparam int unsigned CNT_W = 2;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_A      = 2'd0;
    localparam logic [1:0] REQ_B      = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    localparam logic [CNT_W-1:0] CNT_ZERO = 2'd0;
    localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
    localparam logic [CNT_W-1:0] CNT_SAT  = 2'd2;

    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [KEY_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] result_value;
        logic                    result_valid;
        logic                    last_result;
        logic                    overflowed;
    } out_item_t;

    // Per-entry count pair as held in the count memory.
    typedef struct packed {
        logic [CNT_W-1:0] cnt_a;
        logic [CNT_W-1:0] cnt_b;
    } cnt_pair_t;

    // Result of the shared key comparator.
    typedef struct packed {
        logic eq;       // table key equals the incoming key
        logic gt_last;  // table key is above the last emitted key
        logic lt_best;  // table key is below the best candidate so far
    } cmp_flags_t;

    // Count increment that saturates at two.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        if (c >= CNT_SAT) begin
            r = CNT_SAT;
        end else begin
            r = c + CNT_ONE;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/uibl_key_cmp.sv
// ----------------------------------------------------------------------------
// uibl_key_cmp: shared key comparator
// Compares the key read from the table against the incoming key and
// against the two bounds of the ordered selection pass.
// ----------------------------------------------------------------------------
`default_nettype none

module uibl_key_cmp (
    input  wire logic signed [uibl_pkg::KEY_W-1:0] table_key,
    input  wire logic signed [uibl_pkg::KEY_W-1:0] probe_key,
    input  wire logic signed [uibl_pkg::KEY_W-1:0] last_key,
    input  wire logic signed [uibl_pkg::KEY_W-1:0] best_key,
    output uibl_pkg::cmp_flags_t                   flags
);

    // All comparisons are signed, giving ascending two's complement order.
    always_comb begin
        flags.eq      = (table_key == probe_key);
        flags.gt_last = (table_key > last_key);
        flags.lt_best = (table_key < best_key);
    end

endmodule

`default_nettype wire

>>> rtl/core/unique_in_both_lists_top.sv
// ----------------------------------------------------------------------------
// unique_in_both_lists_top: values seen exactly once in two lists
// Loads list elements into a table of distinct values with saturating
// per-list counts, and on a finish request streams out, in ascending
// order, each value counted once in both lists.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                        | Direction | Payload
//  ---------+------------------------------+-----------+---------------------
//  input    | s_valid, s_ready, s_payload  | in        | req_type, value
//  result   | m_valid, m_ready, m_payload  | out       | result_value,
//           |                              |           | result_valid,
//           |                              |           | last_result,
//           |                              |           | overflowed
//
// Element item: s_ready is low after the transfer while the table is scanned, one entry
// read per cycle, up to the first match, and while the matched or new entry is written.
// Finish item: max(1, q) passes over the table, q being the qualifying count, each
// ending in one result, which waits for m_ready while the output register is full.
// aresetn (synchronous, active low) empties the table and clears the overflow flag;
// a waiting result holds off input unless it is the last result of its finish run.
// ----------------------------------------------------------------------------
`default_nettype none

module unique_in_both_lists_top #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire uibl_pkg::in_item_t  s_payload,

    output logic                     m_valid,
    input  wire logic                m_ready,
    output uibl_pkg::out_item_t      m_payload
);

    // Index width for the table and count width that can also hold the depth.
    localparam int unsigned IW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned KW = uibl_pkg::KEY_W;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE      = 4'b0001,
        ST_ELEM_SCAN = 4'b0010,
        ST_FIN_SCAN  = 4'b0100,
        ST_FIN_EMIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Item being worked on.
    logic signed [KW-1:0] key_reg, key_next;
    logic                 is_b_reg, is_b_next;

    // Table bookkeeping.
    logic [CW-1:0] occ_reg, occ_next;
    logic          ovf_reg, ovf_next;

    // Scan pointer and the read that is in flight.
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic          pend_reg, pend_next;
    logic [IW-1:0] pend_idx_reg, pend_idx_next;

    // Ordered selection state for the finish run.
    logic signed [KW-1:0] last_key_reg, last_key_next;
    logic                 have_last_reg, have_last_next;
    logic signed [KW-1:0] best_key_reg, best_key_next;
    logic                 best_found_reg, best_found_next;
    logic                 first_pass_reg, first_pass_next;
    logic [CW-1:0]        n_total_reg, n_total_next;
    logic [CW-1:0]        n_emit_reg, n_emit_next;

    // Output register.
    uibl_pkg::out_item_t out_reg, out_next;
    logic                out_vld_reg, out_vld_next;

    // Table memories: keys and count pairs, one write and one read port.
    logic [KW-1:0]       key_mem [TABLE_DEPTH];
    uibl_pkg::cnt_pair_t cnt_mem [TABLE_DEPTH];

    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    logic signed [KW-1:0] rd_key_reg;
    uibl_pkg::cnt_pair_t  rd_cnt_reg;

    logic                 wr_key_en;
    logic                 wr_cnt_en;
    logic [IW-1:0]        wr_addr;
    logic [KW-1:0]        wr_key;
    uibl_pkg::cnt_pair_t  wr_cnt;

    // Shared comparator and scan helpers.
    uibl_pkg::cmp_flags_t flags;
    logic                 issue;
    logic                 qual;
    logic                 emit_last;
    logic                 out_free;

    uibl_key_cmp u_key_cmp (
        .table_key (rd_key_reg),
        .probe_key (key_reg),
        .last_key  (last_key_reg),
        .best_key  (best_key_reg),
        .flags     (flags)
    );

    always_ff @(posedge aclk) begin
        if (wr_key_en) begin
            key_mem[wr_addr] <= wr_key;
        end
        if (wr_cnt_en) begin
            cnt_mem[wr_addr] <= wr_cnt;
        end
        if (rd_en) begin
            rd_key_reg <= key_mem[rd_addr];
            rd_cnt_reg <= cnt_mem[rd_addr];
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = out_vld_reg;
    assign m_payload = out_reg;

    // A new read is started while entries below the occupancy remain.
    assign issue     = (scan_idx_reg < occ_reg);
    assign rd_addr   = scan_idx_reg[IW-1:0];
    assign qual      = (rd_cnt_reg.cnt_a == uibl_pkg::CNT_ONE) &&
                       (rd_cnt_reg.cnt_b == uibl_pkg::CNT_ONE);
    assign emit_last = !best_found_reg || (CW'(n_emit_reg + 1'b1) == n_total_reg);
    assign out_free  = !out_vld_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        key_next        = key_reg;
        is_b_next       = is_b_reg;
        occ_next        = occ_reg;
        ovf_next        = ovf_reg;
        scan_idx_next   = scan_idx_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        last_key_next   = last_key_reg;
        have_last_next  = have_last_reg;
        best_key_next   = best_key_reg;
        best_found_next = best_found_reg;
        first_pass_next = first_pass_reg;
        n_total_next    = n_total_reg;
        n_emit_next     = n_emit_reg;
        out_next        = out_reg;
        out_vld_next    = out_vld_reg && !m_ready;

        rd_en     = 1'b0;
        wr_key_en = 1'b0;
        wr_cnt_en = 1'b0;
        wr_addr   = pend_idx_reg;
        wr_key    = key_reg;
        wr_cnt    = rd_cnt_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    key_next      = s_payload.value;
                    is_b_next     = (s_payload.req_type == uibl_pkg::REQ_B);
                    scan_idx_next = '0;
                    pend_next     = 1'b0;
                    unique case (s_payload.req_type)
                        uibl_pkg::REQ_A, uibl_pkg::REQ_B: begin
                            state_next = ST_ELEM_SCAN;
                        end
                        uibl_pkg::REQ_FINISH: begin
                            have_last_next  = 1'b0;
                            best_found_next = 1'b0;
                            first_pass_next = 1'b1;
                            n_total_next    = '0;
                            n_emit_next     = '0;
                            state_next      = ST_FIN_SCAN;
                        end
                        default: begin
                            // Unused request code: the item is taken and dropped.
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_ELEM_SCAN: begin
                rd_en         = issue;
                pend_next     = issue;
                pend_idx_next = scan_idx_reg[IW-1:0];
                if (issue) begin
                    scan_idx_next = CW'(scan_idx_reg + 1'b1);
                end
                priority if (pend_reg && flags.eq) begin
                    // Value already present: bump the count of its list.
                    wr_cnt_en = 1'b1;
                    wr_addr   = pend_idx_reg;
                    if (is_b_reg) begin
                        wr_cnt.cnt_a = rd_cnt_reg.cnt_a;
                        wr_cnt.cnt_b = uibl_pkg::sat_inc(rd_cnt_reg.cnt_b);
                    end else begin
                        wr_cnt.cnt_a = uibl_pkg::sat_inc(rd_cnt_reg.cnt_a);
                        wr_cnt.cnt_b = rd_cnt_reg.cnt_b;
                    end
                    state_next = ST_IDLE;
                end else if (!pend_reg && !issue) begin
                    // Whole table scanned without a match.
                    if (occ_reg < CW'(TABLE_DEPTH)) begin
                        wr_key_en    = 1'b1;
                        wr_cnt_en    = 1'b1;
                        wr_addr      = occ_reg[IW-1:0];
                        wr_key       = key_reg;
                        wr_cnt.cnt_a = is_b_reg ? uibl_pkg::CNT_ZERO : uibl_pkg::CNT_ONE;
                        wr_cnt.cnt_b = is_b_reg ? uibl_pkg::CNT_ONE : uibl_pkg::CNT_ZERO;
                        occ_next     = CW'(occ_reg + 1'b1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_ELEM_SCAN;
                end
            end

            ST_FIN_SCAN: begin
                rd_en         = issue;
                pend_next     = issue;
                pend_idx_next = scan_idx_reg[IW-1:0];
                if (issue) begin
                    scan_idx_next = CW'(scan_idx_reg + 1'b1);
                end
                if (pend_reg && qual) begin
                    if (first_pass_reg) begin
                        n_total_next = CW'(n_total_reg + 1'b1);
                    end
                    // Keep the smallest qualifying key above the last one sent.
                    if ((!have_last_reg || flags.gt_last) &&
                        (!best_found_reg || flags.lt_best)) begin
                        best_key_next   = rd_key_reg;
                        best_found_next = 1'b1;
                    end
                end
                if (!pend_reg && !issue) begin
                    state_next = ST_FIN_EMIT;
                end
            end

            ST_FIN_EMIT: begin
                if (out_free) begin
                    out_vld_next          = 1'b1;
                    out_next.result_value = best_found_reg ? best_key_reg : '0;
                    out_next.result_valid = best_found_reg;
                    out_next.last_result  = emit_last;
                    out_next.overflowed   = ovf_reg;
                    if (emit_last) begin
                        // End of the run: empty the table for the next lists.
                        occ_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        last_key_next   = best_key_reg;
                        have_last_next  = 1'b1;
                        best_found_next = 1'b0;
                        first_pass_next = 1'b0;
                        n_emit_next     = CW'(n_emit_reg + 1'b1);
                        scan_idx_next   = '0;
                        pend_next       = 1'b0;
                        state_next      = ST_FIN_SCAN;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            occ_reg     <= '0;
            ovf_reg     <= 1'b0;
            pend_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            ovf_reg     <= ovf_next;
            pend_reg    <= pend_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg        <= key_next;
        is_b_reg       <= is_b_next;
        scan_idx_reg   <= scan_idx_next;
        pend_idx_reg   <= pend_idx_next;
        last_key_reg   <= last_key_next;
        have_last_reg  <= have_last_next;
        best_key_reg   <= best_key_next;
        best_found_reg <= best_found_next;
        first_pass_reg <= first_pass_next;
        n_total_reg    <= n_total_next;
        n_emit_reg     <= n_emit_next;
        out_reg        <= out_next;
    end

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for unique_in_both_lists_top
// Feeds list A and list B elements and finish requests through the input
// channel, predicts every result with a behavioral table of counts, and
// checks each result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module tb;

    // The block has no code for request value 3; it must ignore such items.
    localparam logic [1:0] REQ_IGNORED = 2'd3;

    localparam int TBL_DEPTH    = 64;
    localparam int TOTAL_ITEMS  = 230;  // element and finish transfers to send
    localparam int QUIET_FROM   = 200;  // no idling on either side after this
    localparam int HOLD_CYCLES  = 400;  // long receiver hold-off
    localparam int DRAIN_CYCLES = 200;  // settle time once nothing is due

    // One row of the directed table. The expected result is typed in only
    // where it is obvious; other rows are checked against the predictor.
    typedef struct packed {
        uibl_pkg::in_item_t  item;
        logic                typed;
        uibl_pkg::out_item_t res;
    } dir_row_t;

    localparam uibl_pkg::out_item_t NO_CHECK = '0;
    localparam int N_DIRECTED = 21;

    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        // A finish right after reset sees an empty table.
        '{'{uibl_pkg::REQ_FINISH, 32'sd0},        1'b1, '{32'sd0, 1'b0, 1'b1, 1'b0}},
        // Extremes of the value range and minus one, each once in both lists.
        '{'{uibl_pkg::REQ_A,      32'sh7FFFFFFF}, 1'b0, NO_CHECK},
        '{'{uibl_pkg::REQ_B,      32'sh7FFFFFFF}, 1'b0, NO_CHECK},
        '{'{uibl_pkg::REQ_A,      32'sh80000000}, 1'b0, NO_CHECK},
        '{'{uibl_pkg::REQ_B,      32'sh80000000}, 1'b0, NO_CHECK},
        '{'{uibl_pkg::REQ_A,      32'shFFFFFFFF}, 1'b0, NO_CHECK},
        '{'{uibl_pkg::REQ_B,      32'shFFFFFFFF}, 1'b0, NO_CHECK},
        // Repeats in list A: the count saturates and the value drops out.
        '{'{uibl_pkg::REQ_A,      32'sd5},        1'b0, NO_CHECK},
        '{'{uibl_pkg::REQ_A,      32'sd5},        1'b0, NO_CHECK},
        '{'{uibl_pkg::REQ_B,      32'sd5},        1'b0, NO_CHECK},
        // Repeats in list B, past the saturation point.
        '{'{uibl_pkg::REQ_B,      32'sd7},        1'b0, NO_CHECK},
        '{'{uibl_pkg::REQ_B,      32'sd7},        1'b0, NO_CHECK},
        '{'{uibl_pkg::REQ_B,      32'sd7},        1'b0, NO_CHECK},
        '{'{uibl_pkg::REQ_A,      32'sd7},        1'b0, NO_CHECK},
        // A value seen in one list only, then an ignored request that would
        // make it qualify if it were taken as a list B element.
        '{'{uibl_pkg::REQ_A,      32'sd1},        1'b0, NO_CHECK},
        '{'{REQ_IGNORED,          32'sd1},        1'b0, NO_CHECK},
        // Three qualifying values in signed order; the finish value is junk.
        '{'{uibl_pkg::REQ_FINISH, 32'shFFFFFFFF}, 1'b0, NO_CHECK},
        '{'{uibl_pkg::REQ_A,      32'sd42},       1'b0, NO_CHECK},
        '{'{uibl_pkg::REQ_B,      32'sd42},       1'b0, NO_CHECK},
        '{'{uibl_pkg::REQ_FINISH, 32'sd0},        1'b1, '{32'sd42, 1'b1, 1'b1, 1'b0}},
        // The previous finish cleared the table.
        '{'{uibl_pkg::REQ_FINISH, 32'sd0},        1'b1, '{32'sd0, 1'b0, 1'b1, 1'b0}}
    };

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    uibl_pkg::in_item_t  s_payload;
    logic                m_valid;
    logic                m_ready;
    uibl_pkg::out_item_t m_payload;

    // Used by the sender, receiver and checker processes.
    bit idle_ok;
    bit hold_off_req;
    int elem_count;
    int fail_count;

    // Predictor state: a table of distinct values with saturating counts.
    logic signed [31:0] key_tab [TBL_DEPTH];
    logic [1:0]         a_cnt   [TBL_DEPTH];
    logic [1:0]         b_cnt   [TBL_DEPTH];
    int                 tab_fill;
    bit                 ovf_seen;

    uibl_pkg::out_item_t emitted_now [$];   // results caused by the latest item
    uibl_pkg::out_item_t due_results [$];   // results predicted and not yet seen

    unique_in_both_lists_top #(
        .TABLE_DEPTH(TBL_DEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Applies one input item to the predicted table and leaves the results it
    // causes in emitted_now. Finish collects values counted once in each list
    // in ascending signed order, then empties the table and the overflow flag.
    function automatic void apply_list_item(input uibl_pkg::in_item_t it);
        int                  i;
        int                  pos;
        bit                  found;
        logic signed [31:0]  picked [$];
        uibl_pkg::out_item_t r;
        emitted_now.delete();
        case (it.req_type)
            uibl_pkg::REQ_A, uibl_pkg::REQ_B: begin
                found = 1'b0;
                for (i = 0; i < tab_fill; i++) begin
                    if (!found && key_tab[i] == it.value) begin
                        found = 1'b1;
                        if (it.req_type == uibl_pkg::REQ_B) begin
                            b_cnt[i] = (b_cnt[i] == uibl_pkg::CNT_SAT) ?
                                       uibl_pkg::CNT_SAT : b_cnt[i] + uibl_pkg::CNT_ONE;
                        end else begin
                            a_cnt[i] = (a_cnt[i] == uibl_pkg::CNT_SAT) ?
                                       uibl_pkg::CNT_SAT : a_cnt[i] + uibl_pkg::CNT_ONE;
                        end
                    end
                end
                if (!found) begin
                    if (tab_fill == TBL_DEPTH) begin
                        // The table is full: a new value is lost.
                        ovf_seen = 1'b1;
                    end else begin
                        key_tab[tab_fill] = it.value;
                        a_cnt[tab_fill]   = (it.req_type == uibl_pkg::REQ_A) ?
                                            uibl_pkg::CNT_ONE : uibl_pkg::CNT_ZERO;
                        b_cnt[tab_fill]   = (it.req_type == uibl_pkg::REQ_B) ?
                                            uibl_pkg::CNT_ONE : uibl_pkg::CNT_ZERO;
                        tab_fill++;
                    end
                end
            end
            uibl_pkg::REQ_FINISH: begin
                for (i = 0; i < tab_fill; i++) begin
                    if (a_cnt[i] == uibl_pkg::CNT_ONE && b_cnt[i] == uibl_pkg::CNT_ONE) begin
                        pos = picked.size();
                        while (pos > 0 && key_tab[i] < picked[pos-1]) begin
                            pos--;
                        end
                        picked.insert(pos, key_tab[i]);
                    end
                end
                if (picked.size() == 0) begin
                    r.result_value = '0;
                    r.result_valid = 1'b0;
                    r.last_result  = 1'b1;
                    r.overflowed   = ovf_seen;
                    emitted_now.insert(emitted_now.size(), r);
                end else begin
                    for (i = 0; i < picked.size(); i++) begin
                        r.result_value = picked[i];
                        r.result_valid = 1'b1;
                        r.last_result  = (i == picked.size() - 1);
                        r.overflowed   = ovf_seen;
                        emitted_now.insert(emitted_now.size(), r);
                    end
                end
                tab_fill = 0;
                ovf_seen = 1'b0;
            end
            default: begin
                // Request code 3 leaves everything as it is.
            end
        endcase
    endfunction

    // A value for random runs, biased toward small numbers and the ends of
    // the signed range so that ordering around zero and the wrap gets used.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 4))
            0:       return $signed($urandom_range(0, 40)) - 32'sd20;
            1:       return 32'sh7FFFFFFF - $signed($urandom_range(0, 3));
            2:       return 32'sh80000000 + $signed($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    // Offers one item and holds it until the transfer happens. Called and
    // returns at a falling edge. A random gap may come first. On the
    // transfer the predictor runs; a typed result replaces its prediction.
    task automatic offer(input uibl_pkg::in_item_t it, input bit typed,
                         input uibl_pkg::out_item_t typed_res);
        int gap;
        if (idle_ok && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 5);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_payload = it;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        apply_list_item(it);
        if (typed) begin
            due_results.insert(due_results.size(), typed_res);
        end else begin
            foreach (emitted_now[i]) due_results.insert(due_results.size(), emitted_now[i]);
        end
        if (it.req_type != REQ_IGNORED) begin
            elem_count++;
        end
        @(negedge aclk);
    endtask

    task automatic send_req(input logic [1:0] req, input logic signed [31:0] val);
        uibl_pkg::in_item_t it;
        it.req_type = req;
        it.value    = val;
        offer(it, 1'b0, NO_CHECK);
    endtask

    // Sender: reset, the directed table, then random runs of elements that
    // each end in a finish request.
    initial begin
        logic signed [31:0] pool [8];
        logic signed [31:0] base;
        int                 pool_size;
        int                 n_elem;
        int                 r;
        bit                 hold_done;
        bit                 overflow_done;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_payload     = '0;
        idle_ok       = 1'b1;
        hold_off_req  = 1'b0;
        elem_count    = 0;
        fail_count    = 0;
        tab_fill      = 0;
        ovf_seen      = 1'b0;
        hold_done     = 1'b0;
        overflow_done = 1'b0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            offer(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].res);
        end

        while (elem_count < TOTAL_ITEMS) begin
            // Some runs go without idling; the tail of the run has none.
            if (elem_count >= QUIET_FROM) begin
                idle_ok = 1'b0;
            end else begin
                idle_ok = ($urandom_range(0, 3) != 0);
            end

            if (!hold_done) begin
                // Six values once in each list, so the finish yields several
                // results. The receiver then holds off for a long stretch
                // while the next run's items keep being offered, so the
                // output register fills and the block stops taking input.
                for (int j = 0; j < 6; j++) pool[j] = pick_value();
                for (int j = 0; j < 6; j++) send_req(uibl_pkg::REQ_A, pool[j]);
                for (int j = 0; j < 6; j++) send_req(uibl_pkg::REQ_B, pool[j]);
                hold_off_req = 1'b1;
                send_req(uibl_pkg::REQ_FINISH, $urandom);
                hold_done = 1'b1;
            end else if (!overflow_done && elem_count >= 60) begin
                // Four qualifying values, then list A fill-up past the table
                // depth. Late new values are dropped; a later hit on a
                // stored value must still count.
                base = $urandom;
                for (int j = 0; j < 4; j++) begin
                    send_req(uibl_pkg::REQ_A, base + j);
                    send_req(uibl_pkg::REQ_B, base + j);
                end
                for (int j = 4; j < TBL_DEPTH + 4; j++) send_req(uibl_pkg::REQ_A, base + j);
                send_req(uibl_pkg::REQ_B, base + 10);
                send_req(uibl_pkg::REQ_FINISH, $urandom);
                overflow_done = 1'b1;
            end else begin
                // Well-formed run from a small pool, with some noise mixed in.
                pool_size = $urandom_range(1, 8);
                for (int j = 0; j < pool_size; j++) pool[j] = pick_value();
                n_elem = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 16);
                for (int j = 0; j < n_elem; j++) begin
                    r = $urandom_range(0, 99);
                    if (r < 7) begin
                        send_req(REQ_IGNORED, $urandom);
                    end else if (r < 15) begin
                        send_req($urandom_range(0, 1) ? uibl_pkg::REQ_B : uibl_pkg::REQ_A,
                                 $urandom);
                    end else begin
                        send_req($urandom_range(0, 1) ? uibl_pkg::REQ_B : uibl_pkg::REQ_A,
                                 pool[$urandom_range(0, pool_size - 1)]);
                    end
                end
                send_req(uibl_pkg::REQ_FINISH, $urandom);
            end
        end
        s_valid = 1'b0;

        while (due_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // Receiver: random ready bursts, plus one long hold-off on request.
    initial begin
        int idle_left;
        idle_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready = 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) @(negedge aclk);
                m_ready = 1'b1;
            end else if (idle_left > 0) begin
                m_ready = 1'b0;
                idle_left--;
            end else if (idle_ok && $urandom_range(0, 3) == 0) begin
                m_ready   = 1'b0;
                idle_left = $urandom_range(1, 5) - 1;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // Result checker: every transfer on the result channel is compared
    // with the oldest prediction still waiting.
    always @(posedge aclk) begin
        uibl_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                $error("unexpected result transfer: value %0d valid %0b last %0b ovf %0b",
                       m_payload.result_value, m_payload.result_valid,
                       m_payload.last_result, m_payload.overflowed);
                fail_count++;
            end else begin
                want = due_results.pop_front();
                if (m_payload.result_value !== want.result_value) begin
                    $error("result_value: expected %0d, got %0d",
                           want.result_value, m_payload.result_value);
                    fail_count++;
                end
                if (m_payload.result_valid !== want.result_valid) begin
                    $error("result_valid: expected %0b, got %0b",
                           want.result_valid, m_payload.result_valid);
                    fail_count++;
                end
                if (m_payload.last_result !== want.last_result) begin
                    $error("last_result: expected %0b, got %0b",
                           want.last_result, m_payload.last_result);
                    fail_count++;
                end
                if (m_payload.overflowed !== want.overflowed) begin
                    $error("overflowed: expected %0b, got %0b",
                           want.overflowed, m_payload.overflowed);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: a correct run finishes far sooner than this.
    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
